### design/tss_pkg.sv
// shared types and constants for the time sync slave
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

	localparam int unsigned NOW_W = 64;
	localparam int unsigned MTS_W = 56;
	localparam int unsigned TAG_W = 5;
	localparam int unsigned NODE_W = 8;
	localparam int unsigned CFG_W = 32;
	localparam int unsigned SYNC_W = 63;

	localparam logic [CFG_W-1:0] PERIOD_RST = 32'd1000000;
	localparam logic [CFG_W-1:0] TIMEOUT_RST = 32'd3000000;
	localparam logic [NODE_W-1:0] NO_MASTER = 8'hFF;
	localparam logic [NODE_W-1:0] NODE_ID_MAX = 8'd127;

	// request command codes
	typedef enum logic {
		CMD_MSG = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	// configuration register indexes
	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_PERIOD = 1'b1
	} reg_idx_t;

	// one input request
	typedef struct packed {
		cmd_t cmd;
		logic [NOW_W-1:0] now;
		logic [NODE_W-1:0] src;
		logic [TAG_W-1:0] tag;
		logic [MTS_W-1:0] mts;
		logic ok;
	} req_t;

	// state snapshot after one request
	typedef struct packed {
		logic [NOW_W-1:0] now;
		logic known;
		logic [NOW_W-1:0] offset;
		logic [NODE_W-1:0] master;
		logic pending;
	} snap_t;

endpackage
`default_nettype wire

### design/time_sync_slave_top.sv
// time sync slave: one result per request, three-stage pipeline
// a request passes the input stage, the snapshot stage and the result register
// throughput: one request per cycle while the result side is not stalled; the state
// update loop closes in stage 1, synced time add and clamp in stage 2
// reset: asynchronous, active low; no master, no offset, config registers at defaults
`timescale 1ns / 1ps
`default_nettype none
module time_sync_slave_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic command,
	input wire logic [63:0] now_us,
	input wire logic [7:0] source_node,
	input wire logic [4:0] transfer_tag,
	input wire logic [55:0] master_prev_tx_us,
	input wire logic payload_ok,
	output logic out_valid,
	input wire logic out_ready,
	output logic [62:0] synced_time_us,
	output logic offset_valid,
	output logic signed [63:0] offset_us,
	output logic signed [7:0] master_node,
	output logic awaiting_adjust
);
	import tss_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic valid_s2;
	snap_t snap_s2;
	snap_t snap;
	logic s2_adv, s1_adv, fire;

	assign s1_adv = !valid_s2 || s2_adv;
	assign in_ready = !valid_s1 || s1_adv;
	assign fire = valid_s1 && s1_adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.cmd <= cmd_t'(command);
			req_s1.now <= now_us;
			req_s1.src <= source_node;
			req_s1.tag <= transfer_tag;
			req_s1.mts <= master_prev_tx_us;
			req_s1.ok <= payload_ok;
		end
	end

	tss_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fire(fire),
		.req(req_s1),
		.snap(snap)
	);

	// snapshot stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			snap_s2 <= snap;
		end
	end

	tss_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.snap_valid(valid_s2),
		.snap(snap_s2),
		.snap_adv(s2_adv),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.synced_time_us(synced_time_us),
		.offset_valid(offset_valid),
		.offset_us(offset_us),
		.master_node(master_node),
		.awaiting_adjust(awaiting_adjust)
	);

endmodule
`default_nettype wire

### design/tss_core.sv
// master election, pairing, offset and staleness state update
`timescale 1ns / 1ps
`default_nettype none
module tss_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic fire,
	input wire tss_pkg::req_t req,
	output tss_pkg::snap_t snap
);
	import tss_pkg::*;

	logic [CFG_W-1:0] timeout_q, period_q;
	logic [NODE_W-1:0] master_q, master_d;
	logic pending_q, pending_d;
	logic [NOW_W-1:0] held_rx_q, held_rx_d;
	logic [TAG_W-1:0] held_tag_q, held_tag_d;
	logic [NOW_W-1:0] offset_q, offset_d;
	logic known_q, known_d;
	logic [NOW_W-1:0] last_rx_q, last_rx_d;

	logic [NOW_W-1:0] gap, tick_gap;
	logic valid_msg, init, better, stale, pair_ok;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		master_d = master_q;
		pending_d = pending_q;
		held_rx_d = held_rx_q;
		held_tag_d = held_tag_q;
		offset_d = offset_q;
		known_d = known_q;
		last_rx_d = last_rx_q;

		gap = req.now - held_rx_q;
		tick_gap = req.now - last_rx_q;
		valid_msg = (req.src <= NODE_ID_MAX) && req.ok;
		init = (master_q == NO_MASTER);
		better = !init && (req.src < master_q);
		stale = !init && (gap > {32'd0, timeout_q});
		pair_ok = pending_q && (req.mts != '0)
			&& (req.tag == held_tag_q + TAG_W'(1))
			&& !(gap > {32'd0, period_q});

		if (req.cmd == CMD_MSG) begin
			if (valid_msg) begin
				if (init || better || stale) begin
					known_d = 1'b0;
					held_rx_d = req.now;
					master_d = req.src;
					held_tag_d = req.tag;
					pending_d = 1'b1;
					last_rx_d = req.now;
				end else if (req.src == master_q) begin
					if (pair_ok) begin
						offset_d = {{(NOW_W-MTS_W){1'b0}}, req.mts} - held_rx_q;
						known_d = 1'b1;
						pending_d = 1'b0;
					end else begin
						held_rx_d = req.now;
						held_tag_d = req.tag;
						pending_d = 1'b1;
					end
					last_rx_d = req.now;
				end
			end
		end else if (known_q && (tick_gap > {32'd0, timeout_q})) begin
			known_d = 1'b0;
		end

		snap.now = req.now;
		snap.known = known_d;
		snap.offset = known_d ? offset_d : '0;
		snap.master = master_d;
		snap.pending = pending_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= NO_MASTER;
			pending_q <= 1'b0;
			known_q <= 1'b0;
			held_rx_q <= '0;
			held_tag_q <= '0;
			offset_q <= '0;
			last_rx_q <= '0;
		end else if (fire) begin
			master_q <= master_d;
			pending_q <= pending_d;
			known_q <= known_d;
			held_rx_q <= held_rx_d;
			held_tag_q <= held_tag_d;
			offset_q <= offset_d;
			last_rx_q <= last_rx_d;
		end
	end

endmodule
`default_nettype wire

### design/tss_out.sv
// synced time with clamping, and the result register
`timescale 1ns / 1ps
`default_nettype none
module tss_out (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic snap_valid,
	input wire tss_pkg::snap_t snap,
	output logic snap_adv,
	output logic out_valid,
	input wire logic out_ready,
	output logic [62:0] synced_time_us,
	output logic offset_valid,
	output logic signed [63:0] offset_us,
	output logic signed [7:0] master_node,
	output logic awaiting_adjust
);
	import tss_pkg::*;

	logic signed [NOW_W+1:0] sum;
	logic [SYNC_W-1:0] synced;

	// exact sum of unsigned now and signed offset, then clamp
	always_comb begin
		sum = $signed({2'b00, snap.now}) + $signed({{2{snap.offset[NOW_W-1]}}, snap.offset});
		if (!snap.known || sum[NOW_W+1]) begin
			synced = '0;
		end else if (sum[NOW_W:SYNC_W] != '0) begin
			synced = '1;
		end else begin
			synced = sum[SYNC_W-1:0];
		end
	end

	assign snap_adv = !out_valid || out_ready;

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (snap_adv) begin
			out_valid <= snap_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (snap_adv && snap_valid) begin
			synced_time_us <= synced;
			offset_valid <= snap.known;
			offset_us <= snap.offset;
			master_node <= snap.master;
			awaiting_adjust <= snap.pending;
		end
	end

endmodule
`default_nettype wire

### bench/tb_time_sync_slave_top.sv
// self-checking testbench for the time sync slave: directed and random requests with a scoreboard
`timescale 1ns / 1ps
module tb_time_sync_slave_top;
	import tss_pkg::*;

	localparam int WATCHDOG_CYCLES = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 6;
	localparam int PHASE_REQS = 270;
	localparam logic [31:0] PHASE_TIMEOUT [PHASES] =
		'{32'd3000000, 32'd0, 32'hFFFFFFFF, 32'd5000, 32'hFFFFFFFF, 32'd1000};
	localparam logic [31:0] PHASE_PERIOD [PHASES] =
		'{32'd1000000, 32'd0, 32'hFFFFFFFF, 32'd2000, 32'd0, 32'hFFFFFFFF};
	localparam logic [64:0] SYNCED_TOP = {2'b00, {63{1'b1}}};

	// one result as seen on the output port
	typedef struct packed {
		logic [62:0] synced;
		logic known;
		logic signed [63:0] offset;
		logic signed [7:0] master;
		logic awaiting;
	} sync_view_t;

	// mirror of the slave state and the queue of results still due
	class sync_tracker;
		logic [31:0] timeout_us;
		logic [31:0] period_us;
		logic [7:0] master;
		bit pending;
		logic [63:0] held_rx;
		logic [4:0] held_tag;
		logic [63:0] offset;
		bit known;
		logic [63:0] last_rx;
		sync_view_t due_views[$];
		int errors;

		function new();
			timeout_us = TIMEOUT_RST;
			period_us = PERIOD_RST;
			master = NO_MASTER;
			pending = 0;
			held_rx = '0;
			held_tag = '0;
			offset = '0;
			known = 0;
			last_rx = '0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			if (idx == REG_TIMEOUT)
				timeout_us = value;
			else
				period_us = value;
		endfunction

		function void hold(req_t r);
			held_rx = r.now;
			master = r.src;
			held_tag = r.tag;
			pending = 1;
		endfunction

		// election, pairing and offset update for one sync message
		function void take_message(req_t r);
			logic [63:0] gap;
			logic [4:0] next_tag;
			bit fresh;
			bit lower;
			bit lapsed;
			if (r.src > NODE_ID_MAX || !r.ok)
				return;
			gap = r.now - held_rx;
			next_tag = held_tag + 5'd1;
			fresh = (master == NO_MASTER);
			lower = !fresh && (r.src < master);
			lapsed = !fresh && (gap > {32'd0, timeout_us});
			if (fresh || lower || lapsed) begin
				known = 0;
				hold(r);
			end else if (r.src == master) begin
				if (pending && (r.mts == '0 || r.tag != next_tag || gap > {32'd0, period_us}))
					pending = 0;
				if (pending) begin
					offset = {8'd0, r.mts} - held_rx;
					known = 1;
					pending = 0;
				end else begin
					hold(r);
				end
			end else begin
				return;
			end
			last_rx = r.now;
		endfunction

		// local time plus signed offset, clamped to the 63-bit range
		function logic [62:0] synced_at(logic [63:0] now);
			logic [64:0] sum;
			logic [63:0] mag;
			if (!known)
				return '0;
			if (!offset[63]) begin
				sum = {1'b0, now} + {1'b0, offset};
			end else begin
				mag = -offset;
				if (now <= mag)
					return '0;
				sum = {1'b0, now - mag};
			end
			return (sum > SYNCED_TOP) ? SYNCED_TOP[62:0] : sum[62:0];
		endfunction

		function void accept_request(req_t r);
			sync_view_t v;
			if (r.cmd == CMD_MSG)
				take_message(r);
			else if (known && (r.now - last_rx) > {32'd0, timeout_us})
				known = 0;
			v.synced = synced_at(r.now);
			v.known = known;
			v.offset = known ? offset : '0;
			v.master = master;
			v.awaiting = pending;
			due_views.push_back(v);
		endfunction

		function void compare(string label, logic [63:0] exp_v, logic [63:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s expected %h got %h", $time, label, exp_v, act_v);
				errors++;
			end
		endfunction

		function void match_result(sync_view_t act);
			sync_view_t e;
			if (due_views.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				errors++;
				return;
			end
			e = due_views.pop_front();
			compare("synced_time_us", {1'b0, e.synced}, {1'b0, act.synced});
			compare("offset_valid", {63'd0, e.known}, {63'd0, act.known});
			compare("offset_us", e.offset, act.offset);
			compare("master_node", {56'd0, e.master}, {56'd0, act.master});
			compare("awaiting_adjust", {63'd0, e.awaiting}, {63'd0, act.awaiting});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = REG_TIMEOUT;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = CMD_MSG;
	logic [63:0] now_us = '0;
	logic [7:0] source_node = '0;
	logic [4:0] transfer_tag = '0;
	logic [55:0] master_prev_tx_us = '0;
	logic payload_ok = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [62:0] synced_time_us;
	logic offset_valid;
	logic signed [63:0] offset_us;
	logic signed [7:0] master_node;
	logic awaiting_adjust;

	sync_tracker tracker;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_output = 0;
	int cycles = 0;

	time_sync_slave_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.now_us(now_us),
		.source_node(source_node),
		.transfer_tag(transfer_tag),
		.master_prev_tx_us(master_prev_tx_us),
		.payload_ok(payload_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.synced_time_us(synced_time_us),
		.offset_valid(offset_valid),
		.offset_us(offset_us),
		.master_node(master_node),
		.awaiting_adjust(awaiting_adjust)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > WATCHDOG_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		sync_view_t act;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				act.synced = synced_time_us;
				act.known = offset_valid;
				act.offset = offset_us;
				act.master = master_node;
				act.awaiting = awaiting_adjust;
				tracker.match_result(act);
			end
			if (hold_output) begin
				hold_output = 0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic req_t make_req(cmd_t c, logic [63:0] now, logic [7:0] src,
			logic [4:0] tag, logic [55:0] mts, logic ok);
		req_t r;
		r.cmd = c;
		r.now = now;
		r.src = src;
		r.tag = tag;
		r.mts = mts;
		r.ok = ok;
		return r;
	endfunction

	// gap around a limit: on it, just past it, zero, or somewhere below
	function automatic logic [63:0] pick_gap(logic [31:0] lim);
		case ($urandom_range(9))
			0: return {32'd0, lim};
			1: return {32'd0, lim} + 64'd1;
			2: return 64'd0;
			3, 4, 5: return {32'd0, $urandom_range(lim)};
			default: return {32'd0, $urandom_range((lim < 32'd50) ? lim : 32'd50)};
		endcase
	endfunction

	// master stamp near local time or anywhere in its range
	function automatic logic [55:0] pick_stamp(logic [63:0] now);
		case ($urandom_range(2))
			0: return {24'($urandom), $urandom};
			1: return now[55:0] + 56'($urandom_range(5000));
			default: return now[55:0] - 56'($urandom_range(5000));
		endcase
	endfunction

	task automatic send(req_t r);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= r.cmd;
		now_us <= r.now;
		source_node <= r.src;
		transfer_tag <= r.tag;
		master_prev_tx_us <= r.mts;
		payload_ok <= r.ok;
		do @(posedge clk); while (!in_ready);
		tracker.accept_request(r);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_reg(idx, value);
		@(posedge clk);
	endtask

	// drop valid and let the pipeline empty out
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due_views.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// corner cases under the reset register values
	task automatic run_directed();
		send(make_req(CMD_TICK, 64'd0, 8'd0, 5'd0, 56'd0, 1'b0));
		send(make_req(CMD_MSG, 64'd100, 8'd200, 5'd0, 56'd1, 1'b1));
		send(make_req(CMD_MSG, 64'd150, 8'd3, 5'd0, 56'd1, 1'b0));
		// first master, tag wraps from 31 to 0 on the adjust
		send(make_req(CMD_MSG, 64'd1000, 8'd10, 5'd31, 56'd7, 1'b1));
		send(make_req(CMD_MSG, 64'd2000, 8'd10, 5'd0, {56{1'b1}}, 1'b1));
		send(make_req(CMD_TICK, 64'd3000, 8'd0, 5'd0, 56'd0, 1'b1));
		send(make_req(CMD_MSG, 64'd3500, 8'd20, 5'd0, 56'd1, 1'b1));
		// re-hold, then wrong tag, zero stamp and too long a pair gap
		send(make_req(CMD_MSG, 64'd4000, 8'd10, 5'd1, 56'd9, 1'b1));
		send(make_req(CMD_MSG, 64'd5000, 8'd10, 5'd3, 56'd100, 1'b1));
		send(make_req(CMD_MSG, 64'd6000, 8'd10, 5'd4, 56'd0, 1'b1));
		send(make_req(CMD_MSG, 64'd1006001, 8'd10, 5'd5, 56'd50, 1'b1));
		// negative offset, then a synced time clamped at zero
		send(make_req(CMD_MSG, 64'd1006011, 8'd10, 5'd6, 56'd1000, 1'b1));
		send(make_req(CMD_MSG, 64'd5, 8'd200, 5'd0, 56'd1, 1'b1));
		// stale offset dropped by a tick
		send(make_req(CMD_TICK, 64'd4006012, 8'd0, 5'd0, 56'd0, 1'b1));
		// lower node wins, boundary node ids, publisher timeout
		send(make_req(CMD_MSG, 64'd5000000, 8'd4, 5'd0, 56'd1, 1'b1));
		send(make_req(CMD_MSG, 64'd5000001, 8'd127, 5'd1, 56'd1, 1'b1));
		send(make_req(CMD_MSG, 64'd5000002, 8'd128, 5'd1, 56'd1, 1'b1));
		send(make_req(CMD_MSG, 64'd8000001, 8'd4, 5'd1, 56'd1, 1'b1));
		// large positive offset, synced time clamped at the top
		send(make_req(CMD_MSG, 64'hC000_0000_0000_0000, 8'd0, 5'd7, 56'd1, 1'b1));
		send(make_req(CMD_MSG, 64'hC000_0000_0000_0064, 8'd0, 5'd8, 56'h10, 1'b1));
		send(make_req(CMD_TICK, 64'hC000_0000_0000_00C8, 8'd0, 5'd0, 56'd0, 1'b1));
		send(make_req(CMD_TICK, 64'h4000_0000_0000_0000, 8'd0, 5'd0, 56'd0, 1'b1));
		// local time wrapping through zero between the pair
		send(make_req(CMD_MSG, {64{1'b1}}, 8'd0, 5'd2, 56'd1, 1'b1));
		send(make_req(CMD_MSG, 64'd0, 8'd0, 5'd3, 56'hAB, 1'b1));
		send(make_req(CMD_TICK, 64'd1, 8'd0, 5'd0, 56'd0, 1'b1));
	endtask

	// mostly well-formed pairs from the current master, plus ticks, rivals and noise
	task automatic run_traffic(int count);
		req_t r;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			r.cmd = CMD_MSG;
			r.src = (tracker.master == NO_MASTER) ? 8'($urandom_range(15)) : tracker.master;
			r.tag = tracker.held_tag + 5'd1;
			r.now = tracker.held_rx + pick_gap(tracker.period_us);
			r.mts = pick_stamp(r.now);
			r.ok = 1'b1;
			if (pick >= 55 && pick < 75) begin
				r.cmd = CMD_TICK;
				r.now = tracker.last_rx + pick_gap(tracker.timeout_us);
				r.src = 8'($urandom);
				r.tag = 5'($urandom);
				r.ok = 1'($urandom);
			end else if (pick >= 75 && pick < 85) begin
				r.src = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(20));
				r.tag = 5'($urandom);
				r.ok = ($urandom_range(9) != 0);
			end else if (pick >= 85 && pick < 93) begin
				case ($urandom_range(2))
					0: r.tag = r.tag + 5'($urandom_range(31, 1));
					1: r.mts = '0;
					default: r.ok = 1'b0;
				endcase
			end else if (pick >= 93) begin
				r.cmd = cmd_t'($urandom_range(1));
				r.now = {$urandom, $urandom};
				r.src = 8'($urandom);
				r.tag = 5'($urandom);
				r.mts = {24'($urandom), $urandom};
				r.ok = 1'($urandom);
			end
			send(r);
		end
	endtask

	initial begin
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 15;
		rx_idle_pct = 69;
		run_directed();

		// register settings and idle patterns per phase
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_reg(REG_TIMEOUT, PHASE_TIMEOUT[p]);
			write_reg(REG_PERIOD, PHASE_PERIOD[p]);
			tx_idle_pct = (p < 2) ? 15 : (p < 4) ? 69 : 0;
			rx_idle_pct = (p < 2) ? 69 : (p < 4) ? 15 : 0;
			if (p == 2)
				hold_output = 1;
			run_traffic(PHASE_REQS);
		end

		drain();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
design/tss_pkg.sv
design/tss_core.sv
design/tss_out.sv
design/time_sync_slave_top.sv
bench/tb_time_sync_slave_top.sv
